### rtl/accel_tilt_pitch_roll_defines.svh
// Assertion macros for the tilt block checker
`ifndef ACCEL_TILT_PITCH_ROLL_DEFINES_SVH
`define ACCEL_TILT_PITCH_ROLL_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define ATP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tilt check failed");

// Next-cycle implication, sampled on clk, quiet during reset
`define ATP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tilt check failed");

`endif

### rtl/atp_pkg.sv
// Shared constants, types and the arctangent table of the tilt block
package atp_pkg;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int ANGLE_FRAC_DEF  = 6;
	localparam int ANG_OUT_W       = 14;
	localparam int RAD_W           = 64;
	localparam int ROOT_W          = 32;
	localparam int MAG_W           = 32;
	localparam int CORDIC_N        = 30;
	localparam int CX_W            = 36;
	localparam int ANG_W           = 33;
	localparam int Z_W             = 31;
	localparam int Q30_SHIFT       = 30;
	localparam int SCALE_MUL       = 9000;
	localparam int SCALE_DIV       = 157;
	localparam logic [Z_W-1:0] HALF_PI_Q30 = 31'd1686629713;

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             neg;
		logic             num_zero;
		logic             den_zero;
		logic             undef;
	} atp_item_t;

	// atan(2^-i) in Q30 radians
	function automatic logic [31:0] atan_q30(input logic [4:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0:  r = 32'd843314857;
			5'd1:  r = 32'd497837829;
			5'd2:  r = 32'd263043837;
			5'd3:  r = 32'd133525159;
			5'd4:  r = 32'd67021687;
			5'd5:  r = 32'd33543516;
			5'd6:  r = 32'd16775851;
			5'd7:  r = 32'd8388437;
			5'd8:  r = 32'd4194283;
			5'd9:  r = 32'd2097149;
			5'd10: r = 32'd1048576;
			5'd11: r = 32'd524288;
			5'd12: r = 32'd262144;
			5'd13: r = 32'd131072;
			5'd14: r = 32'd65536;
			5'd15: r = 32'd32768;
			5'd16: r = 32'd16384;
			5'd17: r = 32'd8192;
			5'd18: r = 32'd4096;
			5'd19: r = 32'd2048;
			5'd20: r = 32'd1024;
			5'd21: r = 32'd512;
			5'd22: r = 32'd256;
			5'd23: r = 32'd128;
			5'd24: r = 32'd64;
			5'd25: r = 32'd32;
			5'd26: r = 32'd16;
			5'd27: r = 32'd8;
			5'd28: r = 32'd4;
			5'd29: r = 32'd2;
			default: r = 32'd0;
		endcase
		return r;
	endfunction
endpackage

### rtl/atp_sample_if.sv
// Handshake channel carrying one three-axis accelerometer sample
interface atp_sample_if import atp_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] accel_x;
	logic signed [SAMPLE_BITS-1:0] accel_y;
	logic signed [SAMPLE_BITS-1:0] accel_z;

	modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
	modport sink (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

### rtl/atp_angle_if.sv
// Handshake channel carrying one pitch and roll result
interface atp_angle_if import atp_pkg::*;;
	logic                        valid;
	logic                        ready;
	logic signed [ANG_OUT_W-1:0] pitch_angle;
	logic signed [ANG_OUT_W-1:0] roll_angle;
	logic                        angle_undefined;

	modport source (output valid, output pitch_angle, output roll_angle,
		output angle_undefined, input ready);
	modport sink (input valid, input pitch_angle, input roll_angle,
		input angle_undefined, output ready);
endinterface

### rtl/atp_sqrt.sv
// Pipelined restoring square root, one root bit per stage
module atp_sqrt import atp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [RAD_W-1:0]   rad,
	input  atp_item_t          in_item,
	output logic               out_valid,
	output logic [ROOT_W-1:0]  root,
	output atp_item_t          out_item
);
	localparam int REM_W = ROOT_W + 4;

	logic              v_s    [ROOT_W];
	logic [RAD_W-1:0]  rad_s  [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	atp_item_t         item_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic              v_in;
		logic [RAD_W-1:0]  rad_in;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		atp_item_t         item_in;
		logic [REM_W-1:0]  acc;
		logic [REM_W-1:0]  trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign rad_in  = rad;
			assign rem_in  = '0;
			assign root_in = '0;
			assign item_in = in_item;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign item_in = item_s[k-1];
		end

		assign acc   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = acc >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= {rad_in[RAD_W-3:0], 2'b00};
				rem_s[k]  <= ge ? acc - trial : acc;
				root_s[k] <= {root_in[ROOT_W-2:0], ge};
				item_s[k] <= item_in;
			end
		end
	end

	assign out_valid = v_s[ROOT_W-1];
	assign root      = root_s[ROOT_W-1];
	assign out_item  = item_s[ROOT_W-1];
endmodule

### rtl/atp_cordic.sv
// Pipelined vectoring CORDIC, one rotation per stage
module atp_cordic import atp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [ROOT_W-1:0]       root,
	input  atp_item_t               in_item,
	output logic                    out_valid,
	output logic signed [ANG_W-1:0] ang,
	output atp_item_t               out_item
);
	logic                   v_s    [CORDIC_N];
	logic signed [CX_W-1:0] x_s    [CORDIC_N];
	logic signed [CX_W-1:0] y_s    [CORDIC_N];
	logic signed [ANG_W-1:0] a_s   [CORDIC_N];
	atp_item_t              item_s [CORDIC_N];

	for (genvar i = 0; i < CORDIC_N; i++) begin : g_step
		logic                    v_in;
		logic signed [CX_W-1:0]  x_in;
		logic signed [CX_W-1:0]  y_in;
		logic signed [ANG_W-1:0] a_in;
		atp_item_t               item_in;
		logic signed [CX_W-1:0]  xs;
		logic signed [CX_W-1:0]  ys;
		logic signed [ANG_W-1:0] step_ang;
		logic                    y_pos;

		if (i == 0) begin : g_first
			assign v_in    = in_valid;
			assign x_in    = $signed({{(CX_W-ROOT_W){1'b0}}, root});
			assign y_in    = $signed({{(CX_W-MAG_W){1'b0}}, in_item.mag});
			assign a_in    = '0;
			assign item_in = in_item;
		end else begin : g_next
			assign v_in    = v_s[i-1];
			assign x_in    = x_s[i-1];
			assign y_in    = y_s[i-1];
			assign a_in    = a_s[i-1];
			assign item_in = item_s[i-1];
		end

		assign xs       = x_in >>> i;
		assign ys       = y_in >>> i;
		assign step_ang = $signed({1'b0, atan_q30(5'(i))});
		assign y_pos    = !y_in[CX_W-1] && (y_in != '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i]    <= y_pos ? x_in + ys : x_in - ys;
				y_s[i]    <= y_pos ? y_in - xs : y_in + xs;
				a_s[i]    <= y_pos ? a_in + step_ang : a_in - step_ang;
				item_s[i] <= item_in;
			end
		end
	end

	assign out_valid = v_s[CORDIC_N-1];
	assign ang       = a_s[CORDIC_N-1];
	assign out_item  = item_s[CORDIC_N-1];
endmodule

### rtl/atp_scale.sv
// Converts a Q30 radian angle to signed 1/2^F degree units on the 180/3.14 scale
module atp_scale import atp_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic signed [ANG_W-1:0]     ang,
	input  atp_item_t                   in_item,
	output logic                        out_valid,
	output logic signed [ANG_OUT_W-1:0] angle,
	output logic                        undef
);
	localparam int P1_W    = 45;
	localparam int SHR     = Q30_SHIFT - ANGLE_FRAC_BITS;
	localparam int TB      = ANGLE_FRAC_BITS + 15;
	localparam int RSH     = TB + 8;
	localparam int RECIP_W = TB + 1;
	localparam int PRW     = (2*TB + 1 > RSH + ANG_OUT_W) ? 2*TB + 1 : RSH + ANG_OUT_W;
	localparam logic [63:0] RECIP =
		((64'd1 << RSH) + 64'(SCALE_DIV - 1)) / 64'(SCALE_DIV);

	logic [Z_W-1:0]       z_sel;
	logic [TB-1:0]        t_val;
	logic [ANG_OUT_W-1:0] q_val;

	logic                  v_s1, v_s2, v_s3;
	logic [P1_W-1:0]       p1_s1;
	logic                  neg_s1, neg_s2;
	logic                  undef_s1, undef_s2, undef_s3;
	logic [PRW-1:0]        prod_s2;
	logic [ANG_OUT_W-1:0]  angle_s3;

	always_comb begin
		if (in_item.num_zero) begin
			z_sel = '0;
		end else if (in_item.den_zero) begin
			z_sel = HALF_PI_Q30;
		end else if (ang[ANG_W-1]) begin
			z_sel = '0;
		end else begin
			z_sel = ang[Z_W-1:0];
		end
	end

	// Floor by 2^(30-F) first, then an exact reciprocal divide by 157
	assign t_val = TB'(p1_s1 >> SHR);
	assign q_val = prod_s2[RSH +: ANG_OUT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1    <= P1_W'(z_sel) * P1_W'(SCALE_MUL);
			neg_s1   <= in_item.neg;
			undef_s1 <= in_item.undef;
			prod_s2  <= PRW'(t_val) * PRW'(RECIP[RECIP_W-1:0]);
			neg_s2   <= neg_s1;
			undef_s2 <= undef_s1;
			angle_s3 <= neg_s2 ? -q_val : q_val;
			undef_s3 <= undef_s2;
		end
	end

	assign out_valid = v_s3;
	assign angle     = $signed(angle_s3);
	assign undef     = undef_s3;
endmodule

### rtl/accel_tilt_pitch_roll.sv
// Tilt sensor: pitch and roll from one three-axis accelerometer sample.
//
// Input channel "sample" takes signed accel_x/y/z; output channel "angle" gives
// pitch_angle and roll_angle in 1/2^ANGLE_FRAC_BITS degree units (180/3.14 scale,
// truncated toward zero) plus angle_undefined for an all-zero sample.
// Both channels move a transaction when valid and ready are high at a clock edge.
//
// Throughput: one sample per cycle unless the receiver stalls the output. The
// pipeline has 67 register stages: 2 stages of squares and sums, 32 square root
// stages (one root bit each), 30 CORDIC stages (one rotation each) and 3 scaling
// stages. Pitch and roll run in two parallel pipelines that share the stall signal.
//
// Reset clears every valid bit; no result shows until new samples enter.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// sample.ready drops in the same cycle; nothing is lost or repeated, and bubbles
// stay in place.
module accel_tilt_pitch_roll import atp_pkg::*; #(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
	input logic          clk,
	input logic          arst_n,
	atp_sample_if.sink   sample,
	atp_angle_if.source  angle
);
	localparam int SW = SAMPLE_BITS;
	localparam int H  = MAG_W - SAMPLE_BITS;

	logic en;

	logic signed [2*SW-1:0] xx_full, yy_full, zz_full;
	logic [SW-1:0]          magx, magy;
	logic [2*SW-1:0]        sum_p, sum_r;

	logic            v_s1, v_s2;
	logic [2*SW-1:0] xx_s1, yy_s1, zz_s1;
	logic [SW-1:0]   magx_s1, magy_s1;
	logic            negx_s1, negy_s1, undef_s1;
	logic [2*SW-1:0] dp_s2, dr_s2;
	atp_item_t       item_p_s2, item_r_s2;

	logic              sq_p_valid, sq_r_valid;
	logic [ROOT_W-1:0] root_p, root_r;
	atp_item_t         sq_p_item, sq_r_item;

	logic                    cd_p_valid, cd_r_valid;
	logic signed [ANG_W-1:0] ang_p, ang_r;
	atp_item_t               cd_p_item, cd_r_item;

	logic pitch_valid, pitch_undef;
	logic roll_valid, roll_undef;

	// Advance everything unless a finished result is held by the receiver
	assign en           = !angle.valid || angle.ready;
	assign sample.ready = en;

	assign xx_full = sample.accel_x * sample.accel_x;
	assign yy_full = sample.accel_y * sample.accel_y;
	assign zz_full = sample.accel_z * sample.accel_z;
	assign magx    = sample.accel_x[SW-1] ? SW'(-sample.accel_x) : SW'(sample.accel_x);
	assign magy    = sample.accel_y[SW-1] ? SW'(-sample.accel_y) : SW'(sample.accel_y);
	assign sum_p   = xx_s1 + zz_s1;
	assign sum_r   = yy_s1 + zz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1    <= xx_full;
			yy_s1    <= yy_full;
			zz_s1    <= zz_full;
			magx_s1  <= magx;
			magy_s1  <= magy;
			negx_s1  <= sample.accel_x[SW-1];
			negy_s1  <= sample.accel_y[SW-1];
			undef_s1 <= (sample.accel_x == '0) && (sample.accel_y == '0) &&
				(sample.accel_z == '0);

			dp_s2              <= sum_p;
			dr_s2              <= sum_r;
			item_p_s2.mag      <= {magy_s1, {H{1'b0}}};
			item_p_s2.neg      <= negy_s1;
			item_p_s2.num_zero <= (magy_s1 == '0);
			item_p_s2.den_zero <= (sum_p == '0);
			item_p_s2.undef    <= undef_s1;
			item_r_s2.mag      <= {magx_s1, {H{1'b0}}};
			item_r_s2.neg      <= negx_s1;
			item_r_s2.num_zero <= (magx_s1 == '0);
			item_r_s2.den_zero <= (sum_r == '0);
			item_r_s2.undef    <= undef_s1;
		end
	end

	atp_sqrt u_sqrt_p (
		.clk, .arst_n, .en,
		.in_valid (v_s2),
		.rad      ({dp_s2, {(2*H){1'b0}}}),
		.in_item  (item_p_s2),
		.out_valid(sq_p_valid),
		.root     (root_p),
		.out_item (sq_p_item)
	);

	atp_sqrt u_sqrt_r (
		.clk, .arst_n, .en,
		.in_valid (v_s2),
		.rad      ({dr_s2, {(2*H){1'b0}}}),
		.in_item  (item_r_s2),
		.out_valid(sq_r_valid),
		.root     (root_r),
		.out_item (sq_r_item)
	);

	atp_cordic u_cordic_p (
		.clk, .arst_n, .en,
		.in_valid (sq_p_valid),
		.root     (root_p),
		.in_item  (sq_p_item),
		.out_valid(cd_p_valid),
		.ang      (ang_p),
		.out_item (cd_p_item)
	);

	atp_cordic u_cordic_r (
		.clk, .arst_n, .en,
		.in_valid (sq_r_valid),
		.root     (root_r),
		.in_item  (sq_r_item),
		.out_valid(cd_r_valid),
		.ang      (ang_r),
		.out_item (cd_r_item)
	);

	atp_scale #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_scale_p (
		.clk, .arst_n, .en,
		.in_valid (cd_p_valid),
		.ang      (ang_p),
		.in_item  (cd_p_item),
		.out_valid(pitch_valid),
		.angle    (angle.pitch_angle),
		.undef    (pitch_undef)
	);

	atp_scale #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_scale_r (
		.clk, .arst_n, .en,
		.in_valid (cd_r_valid),
		.ang      (ang_r),
		.in_item  (cd_r_item),
		.out_valid(roll_valid),
		.angle    (angle.roll_angle),
		.undef    (roll_undef)
	);

	// Both lanes advance in lockstep, so their valid bits and flags always match
	assign angle.valid           = pitch_valid && roll_valid;
	assign angle.angle_undefined = pitch_undef && roll_undef;
endmodule

### rtl/atp_checker.sv
// Port-level checks of the tilt block, bound to its top level
`include "accel_tilt_pitch_roll_defines.svh"

module atp_checker import atp_pkg::*; (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic signed [ANG_OUT_W-1:0] pitch_angle,
	input logic signed [ANG_OUT_W-1:0] roll_angle,
	input logic                        angle_undefined
);
	// A held result stays valid
	`ATP_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid)
	// A held result keeps its angles
	`ATP_ASSERT_NEXT(a_hold_data, out_valid && !out_ready, $stable(pitch_angle) && $stable(roll_angle))
	// A stalled output blocks new samples
	`ATP_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready)
	// An all-zero sample reports zero angles
	`ATP_ASSERT_NOW(a_undef_zero, out_valid && angle_undefined, (pitch_angle == '0) && (roll_angle == '0))
endmodule

bind accel_tilt_pitch_roll atp_checker u_atp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (sample.ready),
	.out_valid       (angle.valid),
	.out_ready       (angle.ready),
	.pitch_angle     (angle.pitch_angle),
	.roll_angle      (angle.roll_angle),
	.angle_undefined (angle.angle_undefined)
);
